@@ rtl/rau_pkg.sv @@
// Package: shared types, codes and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
	localparam int OPERAND_WIDTH = 32;
	localparam int WORD = 64;

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_DIV = 3'd3,
		ACT_CMP = 3'd4
	} action_t;

	localparam logic [1:0] ORD_LESS = 2'd0;
	localparam logic [1:0] ORD_EQUAL = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic signed [31:0] first_num;
		logic signed [31:0] first_den;
		logic signed [31:0] second_num;
		logic signed [31:0] second_den;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] result_num;
		logic signed [63:0] result_den;
		logic [1:0] order;
		logic zero_den;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_COMBINE,
		ST_GCD_START,
		ST_GCD_STEP,
		ST_GCD_NEXT,
		ST_DIVN_START,
		ST_DIVN_STEP,
		ST_DIVD_START,
		ST_DIVD_STEP,
		ST_FINISH,
		ST_OUT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic combine;
		logic gcd_start;
		logic div_start;
		logic div_step;
		logic gcd_next;
		logic div_num_done;
		logic div_den_done;
		logic finish;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic skip_gcd;
		logic rem_zero;
		logic div_last;
	} stat_t;
endpackage

@@ rtl/rational_arithmetic_unit_core.sv @@
// Top level of the rational arithmetic unit: controller, datapath and output register.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid, in_stall, in_data) takes one item: an action and two
//  fractions. Output channel (out_valid, out_stall, out_data) returns one result
//  per item: reduced numerator and denominator, compare order, zero flag.
//  The Euclid gcd steps are skipped when either value is zero. Every division
//  runs on the one restoring divider shared by gcd and both final divisions,
//  so that divider sets the rate; one item is worked at a time, and a new one
//  is taken only after the previous result has been registered.
//  The finished result sits in an output register; the next item is taken
//  while it waits, and the block holds before the next finish until the
//  receiver takes the transfer. A stall holds out_data unchanged.
//  Reset (arst_n low, asynchronous) empties the block and drops any result.
module rational_arithmetic_unit_core #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input rau_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output rau_pkg::out_item_t out_data
);
	rau_pkg::cmd_t cmd;
	rau_pkg::stat_t stat;
	rau_pkg::out_item_t dp_out;
	logic div_for_den;
	logic ctl_stall;
	logic full_q;

	// Hold the finish step while the previous result is still unsent.
	assign ctl_stall = full_q && out_stall;

	rau_controller u_ctl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_stall(ctl_stall),
		.stat(stat), .cmd(cmd), .div_for_den(div_for_den)
	);

	rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk(clk), .in_item(in_data), .cmd(cmd), .div_for_den(div_for_den),
		.stat(stat), .out_item(dp_out)
	);

	// Mark the output register full on finish; clear it on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (cmd.finish) full_q <= 1'b1;
		else if (!out_stall) full_q <= 1'b0;
	end

	assign out_valid = full_q;
	assign out_data = dp_out;
endmodule

@@ rtl/rau_datapath.sv @@
// Datapath: operand products, shared restoring divider, gcd and result registers.
`timescale 1ns / 1ps
module rau_datapath #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
	input logic clk,
	input rau_pkg::in_item_t in_item,
	input rau_pkg::cmd_t cmd,
	input logic div_for_den,
	output rau_pkg::stat_t stat,
	output rau_pkg::out_item_t out_item
);
	localparam int W = rau_pkg::WORD;

	logic [W-1:0] n1_q, d1_q, n2_q, d2_q;
	logic [2:0] act_q;
	logic [W-1:0] p1_q, p2_q, p3_q;
	logic [W-1:0] num_q, den_q;
	logic [W-1:0] ga_q, gb_q;
	logic [W-1:0] dividend_q, divisor_q, quo_q, rem_q;
	logic [6:0] cnt_q;
	logic [W-1:0] rn_q, rd_q;
	rau_pkg::out_item_t res_q;

	function automatic logic [W-1:0] sext(input logic [31:0] raw);
		logic [W-1:0] v;
		v = {{(W-OPERAND_WIDTH){raw[OPERAND_WIDTH-1]}}, raw[OPERAND_WIDTH-1:0]};
		return v;
	endfunction

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	logic [W-1:0] mul_a1, mul_b1, mul_a2, mul_b2;
	logic [W:0] trial;
	logic [W-1:0] rem_sh;

	always_comb begin
		// Products are of sign-extended 32-bit values; keep low 64 bits.
		mul_a1 = n1_q; mul_b1 = d2_q; mul_a2 = n2_q; mul_b2 = d1_q;
		case (act_q)
			rau_pkg::ACT_MUL: begin mul_b1 = n2_q; mul_a2 = d1_q; mul_b2 = d2_q; end
			rau_pkg::ACT_DIV: begin mul_a2 = d1_q; mul_b2 = n2_q; end
			default: ;
		endcase
		rem_sh = {rem_q[W-2:0], dividend_q[W-1]};
		trial = {1'b0, rem_sh} - {1'b0, divisor_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_item.action;
			n1_q <= sext(in_item.first_num);
			d1_q <= sext(in_item.first_den);
			n2_q <= sext(in_item.second_num);
			d2_q <= sext(in_item.second_den);
		end
		// Two multiplier passes: first p1 (the left cross term, or n1*n2 for multiply), then p2 and denominator product p3.
		if (cmd.mul1) p1_q <= W'(signed'(mul_a1[31:0]) * signed'(mul_b1[31:0]));
		if (cmd.mul2) p2_q <= W'(signed'(mul_a2[31:0]) * signed'(mul_b2[31:0]));
		if (cmd.mul2) p3_q <= W'(signed'(d1_q[31:0]) * signed'(d2_q[31:0]));
		if (cmd.combine) begin
			case (act_q)
				rau_pkg::ACT_ADD: begin num_q <= p1_q + p2_q; den_q <= p3_q; end
				rau_pkg::ACT_SUB, rau_pkg::ACT_CMP: begin
					num_q <= p1_q - p2_q; den_q <= p3_q;
				end
				rau_pkg::ACT_MUL, rau_pkg::ACT_DIV: begin num_q <= p1_q; den_q <= p2_q; end
				default: begin num_q <= '0; den_q <= W'(1); end
			endcase
		end
		if (cmd.gcd_start) begin
			ga_q <= mag(num_q);
			gb_q <= mag(den_q);
		end
		if (cmd.gcd_next) begin
			ga_q <= gb_q;
			gb_q <= rem_q;
		end
		if (cmd.div_start) begin
			// In gcd phase divide ga by gb; afterwards divide magnitudes by ga (by 1 when gcd is skipped).
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			if (cmd.gcd_start || cmd.gcd_next) begin
				dividend_q <= cmd.gcd_start ? mag(num_q) : gb_q;
				divisor_q <= cmd.gcd_start ? mag(den_q) : rem_q;
			end else begin
				dividend_q <= div_for_den ? mag(den_q) : mag(num_q);
				divisor_q <= stat.skip_gcd ? W'(1) : ga_q;
			end
		end else if (cmd.div_step) begin
			dividend_q <= {dividend_q[W-2:0], 1'b0};
			cnt_q <= cnt_q + 7'd1;
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
		if (cmd.div_num_done) rn_q <= num_q[W-1] ? (~quo_q + 1'b1) : quo_q;
		if (cmd.div_den_done) rd_q <= den_q[W-1] ? (~quo_q + 1'b1) : quo_q;
		if (cmd.finish) begin
			res_q.result_num <= rn_q;
			res_q.result_den <= rd_q;
			res_q.zero_den <= (rd_q == '0);
			if (act_q == rau_pkg::ACT_CMP && rn_q != '0 && rd_q != '0)
				res_q.order <= (rn_q[W-1] == rd_q[W-1]) ? rau_pkg::ORD_GREATER
					: rau_pkg::ORD_LESS;
			else
				res_q.order <= rau_pkg::ORD_EQUAL;
		end
	end

	assign stat.skip_gcd = (num_q == '0) || (den_q == '0);
	assign stat.rem_zero = (rem_q == '0);
	assign stat.div_last = (cnt_q == 7'(W - 1));
	assign out_item = res_q;
endmodule

@@ rtl/rau_controller.sv @@
// Controller: sequences products, gcd iterations, two divisions and output handshake.
`timescale 1ns / 1ps
module rau_controller (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic out_stall,
	input rau_pkg::stat_t stat,
	output rau_pkg::cmd_t cmd,
	output logic div_for_den
);
	rau_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rau_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		div_for_den = 1'b0;
		case (state_q)
			rau_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin cmd.load = 1'b1; state_d = rau_pkg::ST_MUL1; end
			end
			rau_pkg::ST_MUL1: begin cmd.mul1 = 1'b1; state_d = rau_pkg::ST_MUL2; end
			rau_pkg::ST_MUL2: begin cmd.mul2 = 1'b1; state_d = rau_pkg::ST_COMBINE; end
			rau_pkg::ST_COMBINE: begin cmd.combine = 1'b1; state_d = rau_pkg::ST_GCD_START; end
			rau_pkg::ST_GCD_START: begin
				if (stat.skip_gcd) state_d = rau_pkg::ST_DIVN_START;
				else begin
					cmd.gcd_start = 1'b1; cmd.div_start = 1'b1;
					state_d = rau_pkg::ST_GCD_STEP;
				end
			end
			rau_pkg::ST_GCD_STEP: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = rau_pkg::ST_GCD_NEXT;
			end
			rau_pkg::ST_GCD_NEXT: begin
				// Shift pair (b, a mod b); stop when remainder is zero.
				cmd.gcd_next = 1'b1;
				if (stat.rem_zero) state_d = rau_pkg::ST_DIVN_START;
				else begin cmd.div_start = 1'b1; state_d = rau_pkg::ST_GCD_STEP; end
			end
			rau_pkg::ST_DIVN_START: begin cmd.div_start = 1'b1; state_d = rau_pkg::ST_DIVN_STEP; end
			rau_pkg::ST_DIVN_STEP: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = rau_pkg::ST_DIVD_START;
			end
			rau_pkg::ST_DIVD_START: begin
				cmd.div_num_done = 1'b1;
				cmd.div_start = 1'b1; div_for_den = 1'b1;
				state_d = rau_pkg::ST_DIVD_STEP;
			end
			rau_pkg::ST_DIVD_STEP: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = rau_pkg::ST_FINISH;
			end
			rau_pkg::ST_FINISH: begin
				cmd.div_den_done = 1'b1; state_d = rau_pkg::ST_OUT;
			end
			rau_pkg::ST_OUT: begin
				// Register the result once the output register is free; hold otherwise.
				if (!out_stall) begin
					cmd.finish = 1'b1; state_d = rau_pkg::ST_IDLE;
				end
			end
			default: state_d = rau_pkg::ST_IDLE;
		endcase
	end
endmodule
